>>> design/tps_pkg.sv
// shared types, constants and helpers of the temperature profile sequencer
// no dependencies; compiled first

package tps_pkg;

  localparam int unsigned StageWords = 4;
  localparam int unsigned MaxStages  = 4;
  localparam int unsigned StageLimit = (MaxStages < StageWords) ? MaxStages : StageWords;

  localparam int unsigned CountW   = 3;
  localparam int unsigned StageW   = $clog2(StageWords);
  localparam int unsigned WordW    = 24;
  localparam int unsigned HoldW    = 16;
  localparam int unsigned TargetW  = 8;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned TempW    = 10;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned CfgIdxW  = 3;

  // start of hold: measured minus target at or above this window
  localparam int TempWindow = -1;

  typedef enum logic [CmdW-1:0] {
    CmdUpdate = 2'd0,
    CmdStart  = 2'd1,
    CmdCancel = 2'd2
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStageCount = 3'd0,
    CfgStageWord0 = 3'd1,
    CfgStageWord1 = 3'd2,
    CfgStageWord2 = 3'd3,
    CfgStageWord3 = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [CountW-1:0]                 stage_count;
    logic [StageWords-1:0][WordW-1:0]  stage_word;
  } stage_cfg_t;

  typedef struct packed {
    logic               heater_on;
    logic [TargetW-1:0] setpoint;
    logic [StageW-1:0]  stage_index;
    logic               holding;
    logic [HoldW-1:0]   time_left;
    logic               finished;
  } result_t;

  function automatic logic [HoldW-1:0] word_hold(input logic [WordW-1:0] word);
    return word[HoldW-1:0];
  endfunction

  function automatic logic [TargetW-1:0] word_target(input logic [WordW-1:0] word);
    return word[HoldW +: TargetW];
  endfunction

endpackage

>>> design/tps_if.sv
// handshake channels of the temperature profile sequencer: command in, status out
// depends on tps_pkg for field widths

interface tps_cmd_if;
  logic                                 valid;
  logic                                 ready;
  logic        [tps_pkg::CmdW-1:0]      cmd;
  logic        [tps_pkg::TimeW-1:0]     now_seconds;
  logic signed [tps_pkg::TempW-1:0]     measured_temp;

  modport source (output valid, output cmd, output now_seconds, output measured_temp,
                  input ready);
  modport sink   (input valid, input cmd, input now_seconds, input measured_temp,
                  output ready);
endinterface

interface tps_res_if;
  logic                           valid;
  logic                           ready;
  logic                           heater_on;
  logic [tps_pkg::TargetW-1:0]    setpoint;
  logic [tps_pkg::StageW-1:0]     stage_index;
  logic                           holding;
  logic [tps_pkg::HoldW-1:0]      time_left;
  logic                           finished;

  modport source (output valid, output heater_on, output setpoint, output stage_index,
                  output holding, output time_left, output finished, input ready);
  modport sink   (input valid, input heater_on, input setpoint, input stage_index,
                  input holding, input time_left, input finished, output ready);
endinterface

>>> design/tps_cfg_regs.sv
// recipe registers: stage count and four stage words, written through a plain write port
// depends on tps_pkg

module tps_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tps_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tps_pkg::WordW-1:0]     cfg_wdata_i,
  output tps_pkg::stage_cfg_t           cfg_o
);

  tps_pkg::stage_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (tps_pkg::cfg_idx_e'(cfg_idx_i))
        tps_pkg::CfgStageCount: cfg_d.stage_count   = cfg_wdata_i[tps_pkg::CountW-1:0];
        tps_pkg::CfgStageWord0: cfg_d.stage_word[0] = cfg_wdata_i;
        tps_pkg::CfgStageWord1: cfg_d.stage_word[1] = cfg_wdata_i;
        tps_pkg::CfgStageWord2: cfg_d.stage_word[2] = cfg_wdata_i;
        tps_pkg::CfgStageWord3: cfg_d.stage_word[3] = cfg_wdata_i;
        default:                cfg_d = cfg_q;  // unmapped index, ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/tps_core.sv
// sequencer state, one-step next-state logic and the registered status output
// depends on tps_pkg and the channel interfaces in tps_if.sv

module tps_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tps_pkg::stage_cfg_t  cfg_i,
  tps_cmd_if.sink              cmd_ch,
  tps_res_if.source            res_ch
);

  logic                          run_q, run_d;
  logic [tps_pkg::StageW-1:0]    stage_q, stage_d;
  logic                          hold_q, hold_d;
  logic [tps_pkg::TimeW-1:0]     end_q, end_d;
  logic                          out_valid_q;
  tps_pkg::result_t              res_q, res_d;

  logic                          accept;
  logic [tps_pkg::CountW-1:0]    used;
  logic [tps_pkg::TimeW-1:0]     diff_now;
  logic                          expired;
  logic [tps_pkg::StageW:0]      next_idx;
  logic [tps_pkg::StageW-1:0]    sel;
  logic                          do_check;
  logic                          fin;
  logic [tps_pkg::WordW-1:0]     word_d;
  logic signed [tps_pkg::TempW:0] temp_diff;
  logic                          temp_ok;
  logic [tps_pkg::HoldW-1:0]     left_sat;

  assign cmd_ch.ready = !out_valid_q || res_ch.ready;
  assign accept       = cmd_ch.valid && cmd_ch.ready;

  always_comb begin
    used = (cfg_i.stage_count > tps_pkg::CountW'(tps_pkg::StageLimit))
         ? tps_pkg::CountW'(tps_pkg::StageLimit) : cfg_i.stage_count;
    diff_now = end_q - cmd_ch.now_seconds;
    expired  = (diff_now == '0) || diff_now[tps_pkg::TimeW-1];
    next_idx = {1'b0, stage_q} + 1'b1;

    run_d    = run_q;
    stage_d  = stage_q;
    hold_d   = hold_q;
    end_d    = end_q;
    fin      = 1'b0;
    do_check = 1'b0;
    sel      = stage_q;

    case (tps_pkg::cmd_e'(cmd_ch.cmd))
      tps_pkg::CmdStart: begin
        if (used == '0) begin
          run_d = 1'b0; stage_d = '0; hold_d = 1'b0; end_d = '0;
          fin   = 1'b1;
        end else begin
          run_d    = 1'b1;
          sel      = '0;
          do_check = 1'b1;
        end
      end
      tps_pkg::CmdCancel: begin
        run_d = 1'b0; stage_d = '0; hold_d = 1'b0; end_d = '0;
        fin   = 1'b1;
      end
      default: begin
        // update, and the unused code
        if (run_q) begin
          if (hold_q) begin
            if (expired) begin
              if (next_idx >= {1'b0, used[tps_pkg::CountW-2:0]} && used <= next_idx) begin
                run_d = 1'b0; stage_d = '0; hold_d = 1'b0; end_d = '0;
                fin   = 1'b1;
              end else begin
                sel      = next_idx[tps_pkg::StageW-1:0];
                do_check = 1'b1;
              end
            end
          end else begin
            do_check = 1'b1;
          end
        end
      end
    endcase

    // entering a stage or waiting for temperature: try to start the hold
    temp_diff = $signed({cmd_ch.measured_temp[tps_pkg::TempW-1], cmd_ch.measured_temp})
              - $signed({3'b000, tps_pkg::word_target(cfg_i.stage_word[sel])});
    temp_ok   = temp_diff >= (tps_pkg::TempW+1)'(tps_pkg::TempWindow);
    if (do_check) begin
      stage_d = sel;
      hold_d  = temp_ok;
      end_d   = temp_ok
              ? cmd_ch.now_seconds + tps_pkg::TimeW'(tps_pkg::word_hold(cfg_i.stage_word[sel]))
              : '0;
    end

    word_d   = cfg_i.stage_word[stage_d];
    left_sat = (diff_now[tps_pkg::TimeW-1:tps_pkg::HoldW] != '0)
             ? '1 : diff_now[tps_pkg::HoldW-1:0];

    res_d.heater_on   = run_d;
    res_d.setpoint    = run_d ? tps_pkg::word_target(word_d) : '0;
    res_d.stage_index = run_d ? stage_d : '0;
    res_d.holding     = run_d && hold_d;
    // a hold that goes on keeps its end time, one that just began has the full hold left
    res_d.time_left   = !run_d ? '0
                      : (hold_d && !do_check) ? left_sat
                      : tps_pkg::word_hold(word_d);
    res_d.finished    = fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b0;
      stage_q     <= '0;
      hold_q      <= 1'b0;
      end_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        run_q       <= run_d;
        stage_q     <= stage_d;
        hold_q      <= hold_d;
        end_q       <= end_d;
        out_valid_q <= 1'b1;
      end else if (res_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign res_ch.valid       = out_valid_q;
  assign res_ch.heater_on   = res_q.heater_on;
  assign res_ch.setpoint    = res_q.setpoint;
  assign res_ch.stage_index = res_q.stage_index;
  assign res_ch.holding     = res_q.holding;
  assign res_ch.time_left   = res_q.time_left;
  assign res_ch.finished    = res_q.finished;

endmodule

>>> design/temperature_profile_sequencer.sv
// top level of the ramp/soak temperature profile sequencer
// depends on tps_pkg, tps_if.sv, tps_cfg_regs and tps_core
//
// usage:
//   - program the recipe through the write port: index 0 is the stage count,
//     indexes 1 to 4 are the stage words (hold seconds in bits 15:0, target
//     degrees in bits 23:16); write only while no command is in flight
//   - each transfer on cmd_ch (update, start, cancel, with time and measured
//     temperature) yields exactly one status transfer on res_ch
//   - the status of a command is registered and valid on the cycle after its transfer
//   - throughput: one command per cycle while the receiver takes each status; the next
//     state comes out of one registered step (compares, adds, subtracts)
//   - the status register decouples the sides: cmd_ch.ready stays high while
//     the status slot is empty or being taken in the same cycle
//   - when the receiver stalls, the status holds and cmd_ch.ready is low for
//     as long as a status waits; no status is dropped or repeated
//   - reset clears the recipe registers and the sequencer: heater off, stage 0,
//     no hold, no status pending

module temperature_profile_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tps_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tps_pkg::WordW-1:0]     cfg_wdata_i,
  tps_cmd_if.sink                       cmd_ch,
  tps_res_if.source                     res_ch
);

  tps_pkg::stage_cfg_t cfg;

  // recipe registers
  tps_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // sequencer state and status register
  tps_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .cmd_ch (cmd_ch),
    .res_ch (res_ch)
  );

  // every command transfer produces a status in the next cycle
  a_status_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_ch.valid && cmd_ch.ready) |=> res_ch.valid)
    else $error("no status after command transfer");

  // commands are only held off while a status waits
  a_ready_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_ch.ready |-> (res_ch.valid && !res_ch.ready))
    else $error("command held off without pending status");

  // a stopped sequencer reports a quiet status
  a_off_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_ch.valid && !res_ch.heater_on) |->
      (res_ch.setpoint == '0 && res_ch.stage_index == '0 && !res_ch.holding
       && res_ch.time_left == '0))
    else $error("status not cleared while heater off");

  // finished always comes with the heater switched off
  a_finish_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_ch.valid && res_ch.finished) |-> !res_ch.heater_on)
    else $error("finished while heater on");

endmodule
